@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Forms for the concurrent checks used by otst_checker in the RTL folder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`endif

@@ hw/rtl/otst_pkg.sv @@
// ----------------------------------------------------------------------------
// otst_pkg
// Types, codes and constants of the one-shot timer slot table.
// ----------------------------------------------------------------------------
package otst_pkg;

	localparam int SLOT_COUNT_DEF = 16;
	localparam int SLOT_W         = 6;

	typedef enum logic [1:0] {
		ACT_ADD     = 2'd0,
		ACT_RELEASE = 2'd1,
		ACT_TICK    = 2'd2,
		ACT_UNUSED  = 2'd3
	} action_e;

	typedef enum logic [2:0] {
		KIND_ADDED    = 3'd0,
		KIND_RELEASED = 3'd1,
		KIND_FIRED    = 3'd2,
		KIND_INVALID  = 3'd3,
		KIND_FULL     = 3'd4,
		KIND_TICKDONE = 3'd5
	} kind_e;

	typedef struct packed {
		action_e     action;
		logic [15:0] delay_seconds;
		logic [7:0]  handler_tag;
		logic [31:0] job_tag;
		logic [7:0]  slot_select;
	} in_item_t;

	typedef struct packed {
		kind_e             kind;
		logic [SLOT_W-1:0] slot_number;
		logic [7:0]        fired_handler;
		logic [31:0]       fired_tag;
		logic              last;
	} out_item_t;

	// Token that walks the cell chain, one cell per cycle.
	typedef struct packed {
		logic              valid;
		logic              hit;
		logic [SLOT_W-1:0] hit_slot;
	} token_t;

	// Expiry report of one cell; all zero when the cell does not fire.
	typedef struct packed {
		logic              valid;
		logic [SLOT_W-1:0] slot;
		logic [7:0]        handler;
		logic [31:0]       tag;
	} fire_t;

endpackage

@@ hw/rtl/otst_cell.sv @@
// ----------------------------------------------------------------------------
// otst_cell
// One timer slot: holds its countdown, handler and job tag, acts on the
// command while the token is in it, and hands the token to the next cell.
// ----------------------------------------------------------------------------
module otst_cell
	import otst_pkg::*;
#(
	parameter int CELL_INDEX = 0
) (
	input  logic     clk,
	input  logic     arst_n,
	input  in_item_t cmd,
	input  token_t   tok_in,
	output token_t   tok_out,
	output fire_t    fire
);

	logic        used_q;
	logic        done_q;
	logic [15:0] rem_q;
	logic [7:0]  hnd_q;
	logic [31:0] tag_q;

	logic        add_hit;
	logic        rel_hit;
	logic        tick_here;
	logic [15:0] rem_dec;
	logic        expires;
	token_t      tok_d;

	always_comb begin
		rem_dec   = rem_q - {15'd0, (rem_q != 16'd0)};
		add_hit   = tok_in.valid && (cmd.action == ACT_ADD) && !tok_in.hit && !used_q;
		rel_hit   = tok_in.valid && (cmd.action == ACT_RELEASE) && used_q
			&& (cmd.slot_select == 8'(CELL_INDEX));
		tick_here = tok_in.valid && (cmd.action == ACT_TICK) && used_q && !done_q;
		expires   = tick_here && (rem_dec == 16'd0);

		tok_d = tok_in;
		if (add_hit || rel_hit) begin
			tok_d.hit      = 1'b1;
			tok_d.hit_slot = SLOT_W'(CELL_INDEX);
		end

		fire = '0;
		if (expires) begin
			fire.valid   = 1'b1;
			fire.slot    = SLOT_W'(CELL_INDEX);
			fire.handler = hnd_q;
			fire.tag     = tag_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q  <= 1'b0;
			tok_out <= '0;
		end else begin
			tok_out <= tok_d;
			if (add_hit) begin
				used_q <= 1'b1;
			end else if (rel_hit) begin
				used_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (add_hit) begin
			done_q <= 1'b0;
			rem_q  <= cmd.delay_seconds;
			hnd_q  <= cmd.handler_tag;
			tag_q  <= cmd.job_tag;
		end else if (tick_here) begin
			rem_q <= rem_dec;
			if (expires) begin
				done_q <= 1'b1;
			end
		end
	end

endmodule

@@ hw/rtl/oneshot_timer_slot_table.sv @@
// ----------------------------------------------------------------------------
// oneshot_timer_slot_table
// Table of one-shot countdown timers built as a chain of slot cells.
// ----------------------------------------------------------------------------
// An add, release or tick beat sends a token down the chain of SLOT_COUNT
// cells, one cell per cycle, so busy stays high until the closing beat
// appears, and the next beat can be taken once busy is low again. A tick
// delivers each expiry, in ascending slot order, in the cycle after the token
// was in that slot, and a tick-done beat with last set once the token leaves
// the chain. Add and release report on that same final cycle. A malformed beat
// (unused action, zero delay or handler, slot out of range) is answered with
// an invalid beat in the next cycle and leaves busy low. Every result is shown
// for exactly one cycle with strobe high and must be taken then; there is no
// way to hold it off.
// ----------------------------------------------------------------------------
module oneshot_timer_slot_table
	import otst_pkg::*;
#(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  in_item_t  item,
	output logic      strobe,
	output out_item_t result
);

	in_item_t  cmd_q;
	logic      go_q;
	logic      busy_q;
	logic      strobe_q;
	out_item_t result_q;

	logic      accept;
	logic      immediate;
	token_t    tok_chain [SLOT_COUNT+1];
	fire_t     fires     [SLOT_COUNT];
	fire_t     fire_any;
	token_t    end_tok;
	logic      strobe_d;
	out_item_t result_d;

	assign busy   = busy_q;
	assign accept = start && !busy_q;
	assign strobe = strobe_q;
	assign result = result_q;

	always_comb begin
		unique case (item.action)
			ACT_ADD:     immediate = (item.delay_seconds == 16'd0)
				|| (item.handler_tag == 8'd0);
			ACT_RELEASE: immediate = (item.slot_select >= 8'(SLOT_COUNT));
			ACT_TICK:    immediate = 1'b0;
			default:     immediate = 1'b1;
		endcase
	end

	assign tok_chain[0] = '{valid: go_q, hit: 1'b0, hit_slot: '0};
	assign end_tok      = tok_chain[SLOT_COUNT];

	for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
		otst_cell #(
			.CELL_INDEX(g)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cmd_q),
			.tok_in (tok_chain[g]),
			.tok_out(tok_chain[g+1]),
			.fire   (fires[g])
		);
	end

	// Only the cell holding the token can fire, so an OR merges them.
	always_comb begin
		fire_any = '0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			fire_any = fire_any | fires[i];
		end
	end

	always_comb begin
		strobe_d = 1'b0;
		result_d = '{kind: KIND_INVALID, slot_number: '0, fired_handler: '0,
			fired_tag: '0, last: 1'b1};
		priority if (accept && immediate) begin
			strobe_d = 1'b1;
		end else if (end_tok.valid) begin
			strobe_d = 1'b1;
			unique case (cmd_q.action)
				ACT_ADD: begin
					result_d.kind        = end_tok.hit ? KIND_ADDED : KIND_FULL;
					result_d.slot_number = end_tok.hit ? end_tok.hit_slot : '0;
				end
				ACT_RELEASE: begin
					result_d.kind        = end_tok.hit ? KIND_RELEASED : KIND_INVALID;
					result_d.slot_number = end_tok.hit ? end_tok.hit_slot : '0;
				end
				ACT_TICK: begin
					result_d.kind = KIND_TICKDONE;
				end
				ACT_UNUSED: begin
					result_d.kind = KIND_INVALID;
				end
			endcase
		end else if (fire_any.valid) begin
			strobe_d               = 1'b1;
			result_d.kind          = KIND_FIRED;
			result_d.slot_number   = fire_any.slot;
			result_d.fired_handler = fire_any.handler;
			result_d.fired_tag     = fire_any.tag;
			result_d.last          = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			go_q     <= 1'b0;
			busy_q   <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			go_q     <= accept && !immediate;
			strobe_q <= strobe_d;
			if (accept && !immediate) begin
				busy_q <= 1'b1;
			end else if (end_tok.valid) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		result_q <= result_d;
		if (accept) begin
			cmd_q <= item;
		end
	end

endmodule

@@ hw/rtl/otst_checker.sv @@
// ----------------------------------------------------------------------------
// otst_checker
// Port-level checks of the timer slot table, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module otst_checker
	import otst_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      start,
	input logic      busy,
	input logic      strobe,
	input out_item_t result
);

	logic fired_kind;
	logic status_kind;
	logic payload_zero;

	assign fired_kind   = (result.kind == KIND_FIRED);
	assign status_kind  = (result.kind == KIND_INVALID) || (result.kind == KIND_FULL)
		|| (result.kind == KIND_TICKDONE);
	assign payload_zero = (result.slot_number == '0) && (result.fired_handler == '0)
		&& (result.fired_tag == '0);

	// Only expiry beats may leave more results to follow.
	`ASSERT_IMPLY(a_fired_not_last, clk, arst_n, strobe, fired_kind == !result.last)

	// A walk ends with its closing beat on the cycle busy drops.
	`ASSERT_IMPLY(a_busy_fall_closes, clk, arst_n, $fell(busy), strobe && result.last)

	// Every accepted beat is either answered at once or starts a walk.
	`ASSERT_NEXT(a_accept_answered, clk, arst_n, start && !busy, busy || (strobe && result.last))

	// Status beats that name no slot carry all-zero payload.
	`ASSERT_IMPLY(a_status_zero, clk, arst_n, strobe && status_kind, payload_zero)

endmodule

bind oneshot_timer_slot_table otst_checker u_otst_checker (.*);

@@ tb/otst_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otst_scoreboard
// Watches the command and result channels of the one-shot timer slot table,
// keeps its own copy of the slot table to work out the results of every
// accepted command, and compares them in order with what the block emits.
// ----------------------------------------------------------------------------
module otst_scoreboard
	import otst_pkg::*;
#(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  logic      busy,
	input  in_item_t  item,
	input  logic      strobe,
	input  out_item_t result,
	output int        mismatches,
	output int        outstanding,
	output int        results_seen
);

	logic        armed      [SLOT_COUNT];
	logic        expired    [SLOT_COUNT];
	logic [15:0] countdown  [SLOT_COUNT];
	logic [7:0]  handler_of [SLOT_COUNT];
	logic [31:0] tag_of     [SLOT_COUNT];

	out_item_t   due_q [$];
	out_item_t   want;
	int          fail_total = 0;
	int          seen_total = 0;

	assign mismatches   = fail_total;
	assign results_seen = seen_total;

	function automatic out_item_t beat_of(kind_e k, int slot, logic [7:0] h,
			logic [31:0] t, logic l);
		out_item_t r;
		r.kind          = k;
		r.slot_number   = slot[SLOT_W-1:0];
		r.fired_handler = h;
		r.fired_tag     = t;
		r.last          = l;
		return r;
	endfunction

	// Updates the table copy for one command and queues the beats it causes.
	function automatic void predict_response(in_item_t cmd);
		int free_slot;
		int sel;
		free_slot = -1;
		sel       = int'(cmd.slot_select);
		case (cmd.action)
			ACT_ADD: begin
				if (cmd.delay_seconds == 16'd0 || cmd.handler_tag == 8'd0) begin
					due_q.push_back(beat_of(KIND_INVALID, 0, 8'd0, 32'd0, 1'b1));
				end else begin
					for (int i = 0; i < SLOT_COUNT; i++)
						if (!armed[i] && free_slot < 0)
							free_slot = i;
					if (free_slot < 0) begin
						due_q.push_back(beat_of(KIND_FULL, 0, 8'd0, 32'd0, 1'b1));
					end else begin
						armed[free_slot]      = 1'b1;
						expired[free_slot]    = 1'b0;
						countdown[free_slot]  = cmd.delay_seconds;
						handler_of[free_slot] = cmd.handler_tag;
						tag_of[free_slot]     = cmd.job_tag;
						due_q.push_back(beat_of(KIND_ADDED, free_slot, 8'd0, 32'd0, 1'b1));
					end
				end
			end
			ACT_RELEASE: begin
				if (sel >= SLOT_COUNT || !armed[sel]) begin
					due_q.push_back(beat_of(KIND_INVALID, 0, 8'd0, 32'd0, 1'b1));
				end else begin
					armed[sel] = 1'b0;
					due_q.push_back(beat_of(KIND_RELEASED, sel, 8'd0, 32'd0, 1'b1));
				end
			end
			ACT_TICK: begin
				// A slot that has already fired stays put until it is released.
				for (int i = 0; i < SLOT_COUNT; i++) begin
					if (armed[i] && !expired[i]) begin
						if (countdown[i] != 16'd0)
							countdown[i] = countdown[i] - 16'd1;
						if (countdown[i] == 16'd0) begin
							expired[i] = 1'b1;
							due_q.push_back(beat_of(KIND_FIRED, i, handler_of[i],
								tag_of[i], 1'b0));
						end
					end
				end
				due_q.push_back(beat_of(KIND_TICKDONE, 0, 8'd0, 32'd0, 1'b1));
			end
			default: begin
				due_q.push_back(beat_of(KIND_INVALID, 0, 8'd0, 32'd0, 1'b1));
			end
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				armed[i]      = 1'b0;
				expired[i]    = 1'b0;
				countdown[i]  = '0;
				handler_of[i] = '0;
				tag_of[i]     = '0;
			end
			due_q.delete();
			outstanding <= 0;
		end else begin
			if (strobe) begin
				seen_total++;
				if (due_q.size() == 0) begin
					fail_total++;
					if (fail_total <= 10)
						$display({"%0t: unexpected result beat: ",
							"kind %0d slot %0d handler %02h tag %08h last %b"},
							$realtime, result.kind, result.slot_number,
							result.fired_handler, result.fired_tag, result.last);
				end else begin
					want = due_q.pop_front();
					if (result.kind !== want.kind
							|| result.slot_number !== want.slot_number
							|| result.fired_handler !== want.fired_handler
							|| result.fired_tag !== want.fired_tag
							|| result.last !== want.last) begin
						fail_total++;
						if (fail_total <= 10)
							$display({"%0t: result mismatch: expected kind %0d slot %0d ",
								"handler %02h tag %08h last %b, got kind %0d slot %0d ",
								"handler %02h tag %08h last %b"},
								$realtime, want.kind, want.slot_number, want.fired_handler,
								want.fired_tag, want.last, result.kind, result.slot_number,
								result.fired_handler, result.fired_tag, result.last);
					end
				end
			end
			if (start && !busy)
				predict_response(item);
			outstanding <= due_q.size();
		end
	end

endmodule

@@ tb/oneshot_timer_slot_table_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oneshot_timer_slot_table_test
// Drives add, release and tick commands into the timer slot table: a directed
// opening that hits every result kind and a full-table tick, then random
// traffic under three pacing phases. The scoreboard judges every result beat.
// ----------------------------------------------------------------------------
module oneshot_timer_slot_table_test
	import otst_pkg::*;
();

	localparam int SLOTS         = SLOT_COUNT_DEF;
	localparam int RANDOM_ITEMS  = 200;
	localparam int CYCLE_LIMIT   = 200000;

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	in_item_t  item;
	logic      strobe;
	out_item_t result;

	int        mismatches;
	int        outstanding;
	int        results_seen;
	int        cycles = 0;
	int        idle_pct = 0;
	int        sent = 0;
	int        idle_by_phase [3] = '{21, 52, 0};

	oneshot_timer_slot_table #(
		.SLOT_COUNT(SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.strobe(strobe),
		.result(result)
	);

	otst_scoreboard #(
		.SLOT_COUNT(SLOTS)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.strobe(strobe),
		.result(result),
		.mismatches(mismatches),
		.outstanding(outstanding),
		.results_seen(results_seen)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
	end

	initial begin
		while (cycles < CYCLE_LIMIT)
			@(posedge clk);
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic in_item_t command(action_e a, logic [15:0] d, logic [7:0] h,
			logic [31:0] t, logic [7:0] s);
		in_item_t c;
		c.action        = a;
		c.delay_seconds = d;
		c.handler_tag   = h;
		c.job_tag       = t;
		c.slot_select   = s;
		return c;
	endfunction

	// Mostly well-formed traffic with short delays so that timers really fire;
	// a tenth is malformed.
	function automatic in_item_t random_command();
		in_item_t c;
		int pick;
		c.action        = ACT_TICK;
		c.delay_seconds = 16'($urandom);
		c.handler_tag   = 8'($urandom);
		c.job_tag       = $urandom;
		c.slot_select   = 8'($urandom);
		pick = $urandom_range(99);
		if (pick < 30) begin
			c.action      = ACT_ADD;
			c.handler_tag = 8'($urandom_range(255, 1));
			pick = $urandom_range(9);
			if (pick < 7)
				c.delay_seconds = 16'($urandom_range(4, 1));
			else if (pick < 9)
				c.delay_seconds = 16'($urandom_range(24, 5));
			else
				c.delay_seconds = 16'($urandom_range(65535, 1));
		end else if (pick < 55) begin
			c.action      = ACT_RELEASE;
			c.slot_select = 8'($urandom_range(SLOTS - 1));
		end else if (pick >= 90) begin
			case ($urandom_range(3))
				0: c.action = ACT_UNUSED;
				1: begin
					c.action        = ACT_ADD;
					c.delay_seconds = 16'd0;
				end
				2: begin
					c.action      = ACT_ADD;
					c.handler_tag = 8'd0;
				end
				default: begin
					c.action      = ACT_RELEASE;
					c.slot_select = 8'($urandom_range(255, SLOTS));
				end
			endcase
		end
		return c;
	endfunction

	// Start stays high from one beat to the next unless an idle cycle is drawn.
	task automatic issue(input in_item_t c);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		item  <= c;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sent++;
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		start  = 1'b0;
		item   = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_pct = idle_by_phase[0];
		issue(command(ACT_TICK, 16'd0, 8'd0, 32'd0, 8'd0));
		issue(command(ACT_ADD, 16'd1, 8'hFF, 32'hFFFF_FFFF, 8'd0));
		issue(command(ACT_ADD, 16'hFFFF, 8'd1, 32'd0, 8'hFF));
		issue(command(ACT_ADD, 16'd0, 8'h5A, 32'h1234_5678, 8'd0));
		issue(command(ACT_ADD, 16'd7, 8'd0, 32'h8765_4321, 8'd0));
		issue(command(ACT_RELEASE, 16'd0, 8'd0, 32'd0, 8'(SLOTS)));
		issue(command(ACT_RELEASE, 16'd0, 8'd0, 32'd0, 8'd2));
		issue(command(ACT_UNUSED, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 8'hFF));
		issue(command(ACT_TICK, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 8'hFF));
		issue(command(ACT_RELEASE, 16'd0, 8'd0, 32'd0, 8'd1));
		issue(command(ACT_RELEASE, 16'd0, 8'd0, 32'd0, 8'd0));
		// Fill every slot with a one-second job, overflow once, then fire them all.
		for (int s = 0; s < SLOTS; s++)
			issue(command(ACT_ADD, 16'd1, 8'(s + 1), $urandom, 8'd0));
		issue(command(ACT_ADD, 16'd3, 8'h33, 32'hCAFE_0000, 8'd0));
		issue(command(ACT_TICK, 16'd0, 8'd0, 32'd0, 8'd0));
		drain();

		for (int phase = 0; phase < 3; phase++) begin
			idle_pct = idle_by_phase[phase];
			for (int n = 0; n < (RANDOM_ITEMS + 2) / 3; n++)
				issue(random_command());
		end

		drain();
		repeat (40) @(posedge clk);

		$display("Run covered %0d commands (directed opening, full table, three pacing phases).",
			sent);
		$display("Result beats checked: %0d, mismatches: %0d.", results_seen, mismatches);
		if (mismatches == 0 && outstanding == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/otst_pkg.sv
hw/rtl/otst_cell.sv
hw/rtl/oneshot_timer_slot_table.sv
hw/rtl/otst_checker.sv
tb/otst_checker.sv
tb/oneshot_timer_slot_table_test.sv
